// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define IEE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iee assertion failed");

// Next-cycle implication, off during reset.
`define IEE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iee assertion failed");

// Next-cycle implication, checked through reset too.
`define IEE_ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("iee assertion failed");

`endif

// File: design/iee_pkg.sv
// Shared types, constants and helpers of the infix expression evaluator.
`default_nettype none
package iee_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ACC_W       = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] INT_LIM = 64'h7FFF_FFFF_FFFF_FFFF >> FRAC_BITS;
   localparam logic [63:0] ACC_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [63:0] ACC_LIM = (INT_LIM > ACC_MAX) ? ACC_MAX : INT_LIM;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BADCHAR  = 3'd1,
      ST_DIVZERO  = 3'd2,
      ST_STACK    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TK_DIGIT = 2'd0,
      TK_SPACE = 2'd1,
      TK_OPER  = 2'd2,
      TK_BAD   = 2'd3
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   val;   // digit value or operator code
      logic         last;
   } tok_type;

   typedef struct packed {
      logic        ovf;
      logic [63:0] val;
   } signed_res_type;

   // Apply a sign to a magnitude, flagging results outside the signed range.
   function automatic signed_res_type from_magnitude(input logic neg, input logic [63:0] m);
      signed_res_type r;
      r.ovf = 1'b0;
      r.val = 64'd0;
      if (neg) begin
         if (m > 64'h8000_0000_0000_0000) r.ovf = 1'b1;
         else r.val = 64'd0 - m;
      end else begin
         if (m[63]) r.ovf = 1'b1;
         else r.val = m;
      end
      return r;
   endfunction

   function automatic logic [63:0] magnitude(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

endpackage
`default_nettype wire

// File: design/infix_expression_evaluator.sv
// Infix expression evaluator top level: front end, token queue, evaluation engine.
// Digits and spaces are handled in S_IDLE; an operator scans the operator stack and does
// reductions bounded by the stack depth, each reading two values, then adding/subtracting,
// multiplying (four 32x32 partial products) or dividing (one quotient bit per cycle).
// A last character yields its result after the final reduction, later if the output stalls.
// Synchronous active-high reset empties the queue, stacks and number state.
`default_nettype none
module infix_expression_evaluator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_char_code,
   input  wire logic               req_last_char,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [63:0]      rsp_result_value,
   output logic [2:0]              rsp_status_code
);

   logic             f_push, q_full, q_pop, q_empty;
   iee_pkg::tok_type f_tok, q_head;

   iee_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .tok_push      (f_push),
      .tok_out       (f_tok),
      .tok_full      (q_full)
   );

   iee_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .push_tok (f_tok),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   iee_back u_back (
      .clock            (clock),
      .reset            (reset),
      .tok              (q_head),
      .tok_empty        (q_empty),
      .tok_pop          (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status_code  (rsp_status_code)
   );

endmodule
`default_nettype wire

// File: design/iee_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: design/iee_front.sv
// Front end: registers each character and classifies it into a token.
`default_nettype none
module iee_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [7:0]      req_char_code,
   input  wire logic            req_last_char,
   output logic                 tok_push,
   output iee_pkg::tok_type     tok_out,
   input  wire logic            tok_full
);

   logic             vld_ff, vld_in;
   iee_pkg::tok_type tok_ff, tok_in;
   logic             take;

   assign tok_push  = vld_ff && !tok_full;
   assign req_stall = vld_ff && tok_full;
   assign take      = req_valid && !req_stall;
   assign tok_out   = tok_ff;

   always_comb begin
      tok_in.last = req_last_char;
      tok_in.val  = 4'd0;
      case (req_char_code)
         8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39: begin
            tok_in.kind = iee_pkg::TK_DIGIT;
            tok_in.val  = 4'(req_char_code - 8'h30);
         end
         8'h20: tok_in.kind = iee_pkg::TK_SPACE;
         8'h2B: begin
            tok_in.kind = iee_pkg::TK_OPER;
            tok_in.val  = {2'b00, iee_pkg::OP_ADD};
         end
         8'h2D: begin
            tok_in.kind = iee_pkg::TK_OPER;
            tok_in.val  = {2'b00, iee_pkg::OP_SUB};
         end
         8'h2A: begin
            tok_in.kind = iee_pkg::TK_OPER;
            tok_in.val  = {2'b00, iee_pkg::OP_MUL};
         end
         8'h2F: begin
            tok_in.kind = iee_pkg::TK_OPER;
            tok_in.val  = {2'b00, iee_pkg::OP_DIV};
         end
         default: tok_in.kind = iee_pkg::TK_BAD;
      endcase
   end

   assign vld_in = take || (vld_ff && tok_full);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
      if (take) tok_ff <= tok_in;
   end

endmodule
`default_nettype wire

// File: design/iee_fifo.sv
// Token queue between the front end and the evaluation engine.
`default_nettype none
module iee_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire iee_pkg::tok_type     push_tok,
   output logic                      full,
   input  wire logic                 pop,
   output iee_pkg::tok_type          head,
   output logic                      empty
);

   iee_pkg::tok_type                  slot_ff [iee_pkg::QUEUE_DEPTH];
   logic [iee_pkg::QPTR_W-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [iee_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign full    = cnt_ff == iee_pkg::QCNT_W'(iee_pkg::QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   assign wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + iee_pkg::QCNT_W'(do_push) - iee_pkg::QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wr_ff] <= push_tok;
   end

endmodule
`default_nettype wire

// File: design/iee_back.sv
// Evaluation engine: number gathering, two stacks, and shared mul/div units.
`default_nettype none
module iee_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire iee_pkg::tok_type  tok,
   input  wire logic              tok_empty,
   output logic                   tok_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [63:0]     rsp_result_value,
   output logic [2:0]             rsp_status_code
);

   typedef enum logic [4:0] {
      S_IDLE, S_LOOP, S_LOOP_RD, S_RED, S_RD_A, S_GO, S_ADD, S_MUL, S_MUL_END,
      S_DIV_INIT, S_DIV, S_DIV_END, S_PUSH, S_FINAL, S_FIN, S_FIN_RD, S_OUT
   } state_type;

   localparam int AW = iee_pkg::ADDR_W;
   localparam int CW = iee_pkg::CNT_W;

   state_type              state_ff;
   logic [CW-1:0]          vc_ff, oc_ff;
   logic [iee_pkg::ACC_W-1:0] acc_ff;
   logic                   innum_ff, final_ff, last_ff;
   iee_pkg::status_type    err_ff;
   iee_pkg::op_type        op_ff, red_op_ff;
   logic [63:0]            a_ff, b_ff, x_ff, y_ff, res_ff, r_ff, lo_ff, q_ff;
   logic                   neg_ff;
   logic [127:0]           prod_ff;
   logic [1:0]             mcnt_ff;
   logic [5:0]             dcnt_ff;
   logic                   rspv_ff;
   logic [63:0]            rsp_val_ff;
   iee_pkg::status_type    rsp_st_ff;

   // stack RAM ports
   logic                   v_we, o_we;
   logic [AW-1:0]          v_waddr, v_raddr, o_waddr, o_raddr;
   logic [63:0]            v_wdata, v_rdata;
   logic [1:0]             o_wdata, o_rdata;

   logic [CW-1:0]          vc_m1, vc_m2, oc_m1;
   logic                   v_full, o_full, out_free;
   logic [iee_pkg::ACC_W+3:0] acc_base, acc_next;
   logic [63:0]            flush_val;
   logic [63:0]            sum;
   logic                   sum_ovf;
   logic [31:0]            mx, my;
   logic [63:0]            pp;
   logic [127:0]           pp_sh;
   logic [127:0]           dividend;
   logic                   r_top, r_ge;
   logic [63:0]            r_sh;
   iee_pkg::signed_res_type mul_fm, div_fm;

   assign vc_m1    = vc_ff - 1'b1;
   assign vc_m2    = vc_ff - CW'(2);
   assign oc_m1    = oc_ff - 1'b1;
   assign v_full   = vc_ff >= CW'(iee_pkg::STACK_DEPTH);
   assign o_full   = oc_ff >= CW'(iee_pkg::STACK_DEPTH);
   assign out_free = !rspv_ff || !rsp_stall;
   assign tok_pop  = (state_ff == S_IDLE) && !tok_empty;

   assign acc_base  = innum_ff ? {4'd0, acc_ff} : '0;
   assign acc_next  = (acc_base << 3) + (acc_base << 1) + (iee_pkg::ACC_W+4)'(tok.val);
   assign flush_val = 64'(acc_ff) << iee_pkg::FRAC_BITS;

   always_comb begin
      if (red_op_ff == iee_pkg::OP_ADD) begin
         sum     = a_ff + b_ff;
         sum_ovf = (a_ff[63] == b_ff[63]) && (sum[63] != a_ff[63]);
      end else begin
         sum     = a_ff - b_ff;
         sum_ovf = (a_ff[63] != b_ff[63]) && (sum[63] != a_ff[63]);
      end
   end

   // one 32x32 partial product per cycle
   assign mx = mcnt_ff[0] ? x_ff[63:32] : x_ff[31:0];
   assign my = mcnt_ff[1] ? y_ff[63:32] : y_ff[31:0];
   assign pp = 64'(mx) * 64'(my);
   always_comb begin
      case (mcnt_ff)
         2'd0:    pp_sh = 128'(pp);
         2'd3:    pp_sh = 128'(pp) << 64;
         default: pp_sh = 128'(pp) << 32;
      endcase
   end
   assign mul_fm = iee_pkg::from_magnitude(neg_ff,
                      prod_ff[63+iee_pkg::FRAC_BITS:iee_pkg::FRAC_BITS]);

   assign dividend = 128'(x_ff) << iee_pkg::FRAC_BITS;
   assign r_top    = r_ff[63];
   assign r_sh     = {r_ff[62:0], lo_ff[63]};
   assign r_ge     = r_top || (r_sh >= y_ff);
   assign div_fm   = iee_pkg::from_magnitude(neg_ff, q_ff);

   // stack port control
   always_comb begin
      v_we    = 1'b0;
      v_waddr = vc_ff[AW-1:0];
      v_wdata = flush_val;
      v_raddr = vc_m1[AW-1:0];
      o_we    = 1'b0;
      o_waddr = oc_ff[AW-1:0];
      o_wdata = op_ff;
      o_raddr = oc_m1[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (tok_pop && err_ff == iee_pkg::ST_OK && innum_ff && !v_full &&
                (tok.kind == iee_pkg::TK_SPACE || tok.kind == iee_pkg::TK_OPER))
               v_we = 1'b1;
         end
         S_FINAL: v_we = (err_ff == iee_pkg::ST_OK) && innum_ff && !v_full;
         S_RD_A:  v_raddr = vc_m2[AW-1:0];
         S_PUSH: begin
            v_we    = 1'b1;
            v_wdata = res_ff;
         end
         S_LOOP:  o_we = (err_ff == iee_pkg::ST_OK) && !final_ff && oc_ff == '0 && !o_full;
         S_LOOP_RD: o_we = !final_ff && (op_ff[1] > o_rdata[1]) && !o_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vc_ff    <= '0;
         oc_ff    <= '0;
         acc_ff   <= '0;
         innum_ff <= 1'b0;
         final_ff <= 1'b0;
         err_ff   <= iee_pkg::ST_OK;
         rspv_ff  <= 1'b0;
      end else begin
         if (rspv_ff && !rsp_stall && state_ff != S_OUT) rspv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (tok_pop) begin
                  last_ff  <= tok.last;
                  final_ff <= 1'b0;
                  op_ff    <= iee_pkg::op_type'(tok.val[1:0]);
                  state_ff <= tok.last ? S_FINAL : S_IDLE;
                  if (err_ff == iee_pkg::ST_OK) begin
                     case (tok.kind)
                        iee_pkg::TK_DIGIT: begin
                           innum_ff <= 1'b1;
                           if (64'(acc_next) > iee_pkg::ACC_LIM)
                              err_ff <= iee_pkg::ST_OVERFLOW;
                           else
                              acc_ff <= acc_next[iee_pkg::ACC_W-1:0];
                        end
                        iee_pkg::TK_SPACE, iee_pkg::TK_OPER: begin
                           // flush the pending number
                           if (innum_ff) begin
                              innum_ff <= 1'b0;
                              acc_ff   <= '0;
                              if (v_full) err_ff <= iee_pkg::ST_STACK;
                              else vc_ff <= vc_ff + 1'b1;
                           end
                           if (tok.kind == iee_pkg::TK_OPER) state_ff <= S_LOOP;
                        end
                        default: err_ff <= iee_pkg::ST_BADCHAR;
                     endcase
                  end
               end
            end
            S_LOOP: begin
               if (err_ff != iee_pkg::ST_OK) begin
                  state_ff <= final_ff ? S_FIN : (last_ff ? S_FINAL : S_IDLE);
               end else if (oc_ff == '0) begin
                  if (final_ff) state_ff <= S_FIN;
                  else begin
                     if (o_full) err_ff <= iee_pkg::ST_STACK;
                     else oc_ff <= oc_ff + 1'b1;
                     state_ff <= last_ff ? S_FINAL : S_IDLE;
                  end
               end else begin
                  state_ff <= S_LOOP_RD;
               end
            end
            S_LOOP_RD: begin
               if (final_ff || op_ff[1] <= o_rdata[1]) begin
                  oc_ff     <= oc_m1;
                  red_op_ff <= iee_pkg::op_type'(o_rdata);
                  state_ff  <= S_RED;
               end else begin
                  if (o_full) err_ff <= iee_pkg::ST_STACK;
                  else oc_ff <= oc_ff + 1'b1;
                  state_ff <= last_ff ? S_FINAL : S_IDLE;
               end
            end
            S_RED: begin
               if (vc_ff < CW'(2)) begin
                  err_ff   <= iee_pkg::ST_STACK;
                  state_ff <= S_LOOP;
               end else begin
                  state_ff <= S_RD_A;
               end
            end
            S_RD_A: begin
               b_ff     <= v_rdata;
               state_ff <= S_GO;
            end
            S_GO: begin
               a_ff    <= v_rdata;
               x_ff    <= iee_pkg::magnitude(v_rdata);
               y_ff    <= iee_pkg::magnitude(b_ff);
               neg_ff  <= v_rdata[63] ^ b_ff[63];
               vc_ff   <= vc_m2;
               prod_ff <= '0;
               mcnt_ff <= '0;
               case (red_op_ff)
                  iee_pkg::OP_MUL: state_ff <= S_MUL;
                  iee_pkg::OP_DIV: state_ff <= S_DIV_INIT;
                  default:         state_ff <= S_ADD;
               endcase
            end
            S_ADD: begin
               if (sum_ovf) begin
                  err_ff   <= iee_pkg::ST_OVERFLOW;
                  state_ff <= S_LOOP;
               end else begin
                  res_ff   <= sum;
                  state_ff <= S_PUSH;
               end
            end
            S_MUL: begin
               prod_ff <= prod_ff + pp_sh;
               mcnt_ff <= mcnt_ff + 1'b1;
               if (mcnt_ff == 2'd3) state_ff <= S_MUL_END;
            end
            S_MUL_END: begin
               if (prod_ff[127:64+iee_pkg::FRAC_BITS] != '0 || mul_fm.ovf) begin
                  err_ff   <= iee_pkg::ST_OVERFLOW;
                  state_ff <= S_LOOP;
               end else begin
                  res_ff   <= mul_fm.val;
                  state_ff <= S_PUSH;
               end
            end
            S_DIV_INIT: begin
               r_ff    <= dividend[127:64];
               lo_ff   <= dividend[63:0];
               q_ff    <= '0;
               dcnt_ff <= '0;
               if (y_ff == '0) begin
                  err_ff   <= iee_pkg::ST_DIVZERO;
                  state_ff <= S_LOOP;
               end else if (dividend[127:64] >= y_ff) begin
                  err_ff   <= iee_pkg::ST_OVERFLOW;
                  state_ff <= S_LOOP;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // one quotient bit per cycle
               r_ff    <= r_ge ? r_sh - y_ff : r_sh;
               lo_ff   <= {lo_ff[62:0], 1'b0};
               q_ff    <= {q_ff[62:0], r_ge};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == 6'd63) state_ff <= S_DIV_END;
            end
            S_DIV_END: begin
               if (div_fm.ovf) begin
                  err_ff   <= iee_pkg::ST_OVERFLOW;
                  state_ff <= S_LOOP;
               end else begin
                  res_ff   <= div_fm.val;
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               vc_ff    <= vc_ff + 1'b1;
               state_ff <= S_LOOP;
            end
            S_FINAL: begin
               if (err_ff == iee_pkg::ST_OK && innum_ff) begin
                  innum_ff <= 1'b0;
                  acc_ff   <= '0;
                  if (v_full) err_ff <= iee_pkg::ST_STACK;
                  else vc_ff <= vc_ff + 1'b1;
               end
               final_ff <= 1'b1;
               state_ff <= S_LOOP;
            end
            S_FIN: begin
               res_ff <= '0;
               if (err_ff != iee_pkg::ST_OK) state_ff <= S_OUT;
               else if (vc_ff == '0) begin
                  err_ff   <= iee_pkg::ST_STACK;
                  state_ff <= S_OUT;
               end else state_ff <= S_FIN_RD;
            end
            S_FIN_RD: begin
               res_ff   <= v_rdata;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rspv_ff    <= 1'b1;
                  rsp_val_ff <= res_ff;
                  rsp_st_ff  <= err_ff;
                  vc_ff      <= '0;
                  oc_ff      <= '0;
                  acc_ff     <= '0;
                  innum_ff   <= 1'b0;
                  err_ff     <= iee_pkg::ST_OK;
                  final_ff   <= 1'b0;
                  state_ff   <= S_IDLE;
               end else if (rspv_ff && !rsp_stall) begin
                  rspv_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rspv_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_status_code  = rsp_st_ff;

   iee_ram #(.WIDTH(64), .DEPTH(iee_pkg::STACK_DEPTH)) u_value_stack (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   iee_ram #(.WIDTH(2), .DEPTH(iee_pkg::STACK_DEPTH)) u_operator_stack (
      .clock   (clock),
      .wr_en   (o_we),
      .wr_addr (o_waddr),
      .wr_data (o_wdata),
      .rd_addr (o_raddr),
      .rd_data (o_rdata)
   );

endmodule
`default_nettype wire

// File: design/iee_checker.sv
// Port-level checks for the infix expression evaluator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module iee_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic signed [63:0] rsp_result_value,
   input wire logic [2:0]        rsp_status_code
);

   logic rsp_err;
   logic rsp_in_range;

   assign rsp_err      = rsp_valid && (rsp_status_code != iee_pkg::ST_OK);
   assign rsp_in_range = rsp_status_code <= iee_pkg::ST_OVERFLOW;

   `IEE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `IEE_ASSERT_IMPL(a_err_zero, clock, reset, rsp_err, rsp_result_value == 64'sd0)
   `IEE_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_in_range)
   `IEE_ASSERT_NEXT_RAW(a_reset_quiet, clock, reset, !rsp_valid && !req_stall)

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_status_code  (rsp_status_code)
);
`default_nettype wire
